// ----- hdl/xtl_pkg.sv -----
// Shared types and fixed constants of the XYZ to L*u*v* converter.
// Used by xtl_lum, xtl_chroma and the top level xyz_to_cie_luv; no dependencies.
package xtl_pkg;

	typedef struct packed {
		logic [15:0] x;
		logic [15:0] y;
		logic [15:0] z;
	} xyz_t;

	typedef struct packed {
		logic [15:0] wx;
		logic [15:0] wy;
		logic [15:0] wz;
	} white_t;

	localparam logic [1:0] RegWhiteX = 2'd0;
	localparam logic [1:0] RegWhiteY = 2'd1;
	localparam logic [1:0] RegWhiteZ = 2'd2;

	localparam logic [15:0] WhiteXReset = 16'd31145;
	localparam logic [15:0] WhiteYReset = 16'd32768;
	localparam logic [15:0] WhiteZReset = 16'd35679;

	localparam int TgtBits    = 54;
	localparam int CbrtSteps  = 18;
	localparam int LinBits    = 12;
	localparam int ChromaBits = 18;

	localparam int LinMul    = 24389;
	localparam int LinCmp    = 216;
	localparam int LinBias   = 27;
	localparam int LinDen    = 54;
	localparam int BrightMul = 13;
	localparam int CbrtMul   = 29696;
	localparam int CbrtRnd   = 32768;
	localparam int LOffset   = 4096;
	localparam int KU        = 52;
	localparam int KV        = 117;

	localparam logic [17:0] ChromaPosMax = 18'd131071;
	localparam logic [17:0] ChromaNegMax = 18'd131072;

endpackage

// ----- hdl/xtl_lum.sv -----
// Lightness pipeline: restoring divisions, bitwise cube root and the final L* select.
// Depends on xtl_pkg; carries the pixel along for the chroma pipeline.
module xtl_lum (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_valid,
	input  xtl_pkg::xyz_t in_pix,
	input  logic [15:0]   white_y,
	output logic          out_valid,
	output xtl_pkg::xyz_t out_pix,
	output logic [15:0]   lightness
);

	localparam int TgtBits   = xtl_pkg::TgtBits;
	localparam int CbrtSteps = xtl_pkg::CbrtSteps;
	localparam int LinBits   = xtl_pkg::LinBits;

	logic [30:0] ymul;
	logic        lin_c;
	logic        bright_c;
	logic [39:0] n1_c;
	logic [21:0] w54;

	assign ymul     = 31'(in_pix.y) * 31'(xtl_pkg::LinMul);
	assign lin_c    = ymul <= 31'(xtl_pkg::LinCmp) * 31'(white_y);
	assign bright_c = 20'(in_pix.y) > 20'(xtl_pkg::BrightMul) * 20'(white_y);
	assign n1_c     = {ymul, 9'd0} + 40'(xtl_pkg::LinBias) * 40'(white_y);
	assign w54      = 22'(xtl_pkg::LinDen) * 22'(white_y);

	logic                  dv_v_s      [0:TgtBits];
	xtl_pkg::xyz_t         dv_pix_s    [0:TgtBits];
	logic                  dv_lin_s    [0:TgtBits];
	logic                  dv_bright_s [0:TgtBits];
	logic [15:0]           dv_rem_s    [0:TgtBits];
	logic [TgtBits-1:0]    dv_q_s      [0:TgtBits];
	logic [LinBits-1:0]    dl_q_s      [0:TgtBits];
	logic [21:0]           dl_rem_s    [0:LinBits];
	logic [LinBits-1:0]    dl_n_s      [0:LinBits];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_v_s[0] <= 1'b0;
		end else if (en) begin
			dv_v_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dv_pix_s[0]    <= in_pix;
			dv_lin_s[0]    <= lin_c;
			dv_bright_s[0] <= bright_c;
			dv_rem_s[0]    <= 16'(in_pix.y[15:6]);
			dv_q_s[0]      <= '0;
			dl_q_s[0]      <= '0;
			dl_rem_s[0]    <= 22'(n1_c[39:LinBits]);
			dl_n_s[0]      <= n1_c[LinBits-1:0];
		end
	end

	for (genvar k = 0; k < TgtBits; k++) begin : g_div
		logic        nbit;
		logic [16:0] trial;
		logic        ge;

		if (k < 6) begin : g_nb
			assign nbit = dv_pix_s[k].y[5-k];
		end else begin : g_nz
			assign nbit = 1'b0;
		end

		assign trial = {dv_rem_s[k], nbit};
		assign ge    = trial >= {1'b0, white_y};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_v_s[k+1] <= 1'b0;
			end else if (en) begin
				dv_v_s[k+1] <= dv_v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				dv_pix_s[k+1]    <= dv_pix_s[k];
				dv_lin_s[k+1]    <= dv_lin_s[k];
				dv_bright_s[k+1] <= dv_bright_s[k];
				dv_rem_s[k+1]    <= ge ? 16'(trial - {1'b0, white_y}) : trial[15:0];
				dv_q_s[k+1]      <= {dv_q_s[k][TgtBits-2:0], ge};
			end
		end

		if (k < LinBits) begin : g_lin
			logic [22:0] ltrial;
			logic        lge;

			assign ltrial = {dl_rem_s[k], dl_n_s[k][LinBits-1-k]};
			assign lge    = ltrial >= {1'b0, w54};

			always_ff @(posedge clk) begin
				if (en) begin
					dl_rem_s[k+1] <= lge ? 22'(ltrial - {1'b0, w54}) : ltrial[21:0];
					dl_n_s[k+1]   <= dl_n_s[k];
					dl_q_s[k+1]   <= {dl_q_s[k][LinBits-2:0], lge};
				end
			end
		end else begin : g_lin_carry
			always_ff @(posedge clk) begin
				if (en) begin
					dl_q_s[k+1] <= dl_q_s[k];
				end
			end
		end
	end

	logic                  cb_v_s      [1:CbrtSteps];
	xtl_pkg::xyz_t         cb_pix_s    [1:CbrtSteps];
	logic                  cb_lin_s    [1:CbrtSteps];
	logic                  cb_bright_s [1:CbrtSteps];
	logic [LinBits-1:0]    cb_lq_s     [1:CbrtSteps];
	logic [TgtBits-1:0]    cb_t_s      [1:CbrtSteps];
	logic [37:0]           cb_r_s      [1:CbrtSteps];
	logic [17:0]           cb_m_s      [1:CbrtSteps];
	logic [35:0]           cb_sq_s     [1:CbrtSteps];

	for (genvar j = 0; j < CbrtSteps; j++) begin : g_cbrt
		logic               v_i;
		xtl_pkg::xyz_t      pix_i;
		logic               lin_i;
		logic               br_i;
		logic [LinBits-1:0] lq_i;
		logic [TgtBits-1:0] t_i;
		logic [37:0]        r_i;
		logic [17:0]        m_i;
		logic [35:0]        sq_i;
		logic [40:0]        r8;
		logic [40:0]        tt;
		logic               ge;

		if (j == 0) begin : g_first
			assign v_i   = dv_v_s[TgtBits];
			assign pix_i = dv_pix_s[TgtBits];
			assign lin_i = dv_lin_s[TgtBits];
			assign br_i  = dv_bright_s[TgtBits];
			assign lq_i  = dl_q_s[TgtBits];
			assign t_i   = dv_q_s[TgtBits];
			assign r_i   = '0;
			assign m_i   = '0;
			assign sq_i  = '0;
		end else begin : g_next
			assign v_i   = cb_v_s[j];
			assign pix_i = cb_pix_s[j];
			assign lin_i = cb_lin_s[j];
			assign br_i  = cb_bright_s[j];
			assign lq_i  = cb_lq_s[j];
			assign t_i   = cb_t_s[j];
			assign r_i   = cb_r_s[j];
			assign m_i   = cb_m_s[j];
			assign sq_i  = cb_sq_s[j];
		end

		assign r8 = {r_i, t_i[TgtBits-1-3*j -: 3]};
		assign tt = 41'(sq_i) * 41'(12) + 41'(m_i) * 41'(6) + 41'(1);
		assign ge = r8 >= tt;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				cb_v_s[j+1] <= 1'b0;
			end else if (en) begin
				cb_v_s[j+1] <= v_i;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				cb_pix_s[j+1]    <= pix_i;
				cb_lin_s[j+1]    <= lin_i;
				cb_bright_s[j+1] <= br_i;
				cb_lq_s[j+1]     <= lq_i;
				cb_t_s[j+1]      <= t_i;
				cb_r_s[j+1]      <= ge ? 38'(r8 - tt) : 38'(r8);
				cb_m_s[j+1]      <= {m_i[16:0], ge};
				cb_sq_s[j+1]     <= ge ? 36'({sq_i, 2'b00} + {m_i, 2'b00} + 36'(1))
				                       : 36'({sq_i, 2'b00});
			end
		end
	end

	logic               v_s74;
	xtl_pkg::xyz_t      pix_s74;
	logic               lin_s74;
	logic               bright_s74;
	logic [LinBits-1:0] lq_s74;
	logic [33:0]        prod_s74;
	logic               v_s75;
	xtl_pkg::xyz_t      pix_s75;
	logic [15:0]        light_s75;
	logic [17:0]        hi;
	logic [17:0]        lcb;
	logic [15:0]        lsel;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s74 <= 1'b0;
			v_s75 <= 1'b0;
		end else if (en) begin
			v_s74 <= cb_v_s[CbrtSteps];
			v_s75 <= v_s74;
		end
	end

	assign hi  = prod_s74[33:16];
	assign lcb = (hi < 18'(xtl_pkg::LOffset)) ? 18'd0 : hi - 18'(xtl_pkg::LOffset);

	always_comb begin
		if (lin_s74) begin
			lsel = 16'(lq_s74);
		end else if (bright_s74 || lcb[17:16] != 2'b00) begin
			lsel = 16'hFFFF;
		end else begin
			lsel = lcb[15:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pix_s74    <= cb_pix_s[CbrtSteps];
			lin_s74    <= cb_lin_s[CbrtSteps];
			bright_s74 <= cb_bright_s[CbrtSteps];
			lq_s74     <= cb_lq_s[CbrtSteps];
			prod_s74   <= 34'(cb_m_s[CbrtSteps]) * 34'(xtl_pkg::CbrtMul)
			              + 34'(xtl_pkg::CbrtRnd);
			pix_s75    <= pix_s74;
			light_s75  <= lsel;
		end
	end

	assign out_valid = v_s75;
	assign out_pix   = pix_s75;
	assign lightness = light_s75;

endmodule

// ----- hdl/xtl_chroma.sv -----
// Chroma pipeline: cross products, scaling by L*, restoring division and saturation.
// Depends on xtl_pkg; fed by xtl_lum with the lightness and the pixel.
module xtl_chroma (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_valid,
	input  xtl_pkg::xyz_t      in_pix,
	input  logic [15:0]        in_light,
	input  xtl_pkg::white_t    white,
	output logic               out_valid,
	output logic [15:0]        lightness,
	output logic signed [17:0] u_star,
	output logic signed [17:0] v_star
);

	localparam int ChromaBits = xtl_pkg::ChromaBits;

	typedef struct packed {
		logic [41:0]           rem;
		logic [ChromaBits-1:0] low;
		logic [ChromaBits-1:0] q;
		logic                  sat;
		logic                  neg;
	} lane_t;

	function automatic lane_t div_step(lane_t a, logic [41:0] den);
		lane_t       r;
		logic [42:0] trial;
		logic        ge;
		trial = {a.rem, a.low[ChromaBits-1]};
		ge    = trial >= {1'b0, den};
		r     = a;
		r.rem = ge ? 42'(trial - {1'b0, den}) : trial[41:0];
		r.low = {a.low[ChromaBits-2:0], 1'b0};
		r.q   = {a.q[ChromaBits-2:0], ge};
		return r;
	endfunction

	function automatic logic [17:0] clip(lane_t a);
		logic [17:0] mag;
		if (a.neg) begin
			mag = (a.sat || a.q > xtl_pkg::ChromaNegMax) ? xtl_pkg::ChromaNegMax : a.q;
			return 18'(18'd0 - mag);
		end
		return (a.sat || a.q > xtl_pkg::ChromaPosMax) ? xtl_pkg::ChromaPosMax : a.q;
	endfunction

	logic [20:0] dn_c;
	assign dn_c = 21'(white.wx) + 21'(white.wy) * 21'(15) + 21'(white.wz) * 21'(3);

	logic        v_s1, v_s2, v_s3, v_s4, v_s5;
	logic [15:0] l_s1, l_s2, l_s3, l_s4, l_s5;
	logic [15:0] x_s1, y_s1;
	logic [20:0] d_s1;
	logic [36:0] px_s2, nx_s2, py_s2, ny_s2;
	logic [41:0] den_s2, den_s3, den_s4, den_s5;
	logic [36:0] du_s3, dv_s3;
	logic        negu_s3, negv_s3, negu_s4, negv_s4, negu_s5, negv_s5;
	logic [52:0] mu_s4, mv_s4;
	logic [60:0] nu_s5, nv_s5;
	logic        zd;

	assign zd = d_s1 == 21'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1    <= in_pix.x;
			y_s1    <= in_pix.y;
			l_s1    <= in_light;
			d_s1    <= 21'(in_pix.x) + 21'(in_pix.y) * 21'(15) + 21'(in_pix.z) * 21'(3);
			px_s2   <= zd ? 37'd0 : 37'(x_s1) * 37'(dn_c);
			nx_s2   <= zd ? 37'(white.wx) : 37'(white.wx) * 37'(d_s1);
			py_s2   <= zd ? 37'd0 : 37'(y_s1) * 37'(dn_c);
			ny_s2   <= zd ? 37'(white.wy) : 37'(white.wy) * 37'(d_s1);
			den_s2  <= zd ? 42'(dn_c) : 42'(d_s1) * 42'(dn_c);
			l_s2    <= l_s1;
			negu_s3 <= nx_s2 > px_s2;
			du_s3   <= (nx_s2 > px_s2) ? nx_s2 - px_s2 : px_s2 - nx_s2;
			negv_s3 <= ny_s2 > py_s2;
			dv_s3   <= (ny_s2 > py_s2) ? ny_s2 - py_s2 : py_s2 - ny_s2;
			den_s3  <= den_s2;
			l_s3    <= l_s2;
			mu_s4   <= 53'(l_s3) * 53'(du_s3);
			mv_s4   <= 53'(l_s3) * 53'(dv_s3);
			negu_s4 <= negu_s3;
			negv_s4 <= negv_s3;
			den_s4  <= den_s3;
			l_s4    <= l_s3;
			nu_s5   <= 61'(mu_s4) * 61'(xtl_pkg::KU) + 61'(den_s4[41:1]);
			nv_s5   <= 61'(mv_s4) * 61'(xtl_pkg::KV) + 61'(den_s4[41:1]);
			negu_s5 <= negu_s4;
			negv_s5 <= negv_s4;
			den_s5  <= den_s4;
			l_s5    <= l_s4;
		end
	end

	logic        qd_v_s   [0:ChromaBits];
	logic [15:0] qd_l_s   [0:ChromaBits];
	logic [41:0] qd_den_s [0:ChromaBits];
	lane_t       qd_u_s   [0:ChromaBits];
	lane_t       qd_w_s   [0:ChromaBits];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qd_v_s[0] <= 1'b0;
		end else if (en) begin
			qd_v_s[0] <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			qd_l_s[0]       <= l_s5;
			qd_den_s[0]     <= den_s5;
			qd_u_s[0].rem   <= nu_s5[59:18];
			qd_u_s[0].low   <= nu_s5[17:0];
			qd_u_s[0].q     <= '0;
			qd_u_s[0].sat   <= nu_s5[60:18] >= 43'(den_s5);
			qd_u_s[0].neg   <= negu_s5;
			qd_w_s[0].rem   <= nv_s5[59:18];
			qd_w_s[0].low   <= nv_s5[17:0];
			qd_w_s[0].q     <= '0;
			qd_w_s[0].sat   <= nv_s5[60:18] >= 43'(den_s5);
			qd_w_s[0].neg   <= negv_s5;
		end
	end

	for (genvar k = 0; k < ChromaBits; k++) begin : g_qdiv
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				qd_v_s[k+1] <= 1'b0;
			end else if (en) begin
				qd_v_s[k+1] <= qd_v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				qd_l_s[k+1]   <= qd_l_s[k];
				qd_den_s[k+1] <= qd_den_s[k];
				qd_u_s[k+1]   <= div_step(qd_u_s[k], qd_den_s[k]);
				qd_w_s[k+1]   <= div_step(qd_w_s[k], qd_den_s[k]);
			end
		end
	end

	logic        v_s25;
	logic [15:0] l_s25;
	logic [17:0] u_s25, w_s25;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s25 <= 1'b0;
		end else if (en) begin
			v_s25 <= qd_v_s[ChromaBits];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			l_s25 <= qd_l_s[ChromaBits];
			u_s25 <= clip(qd_u_s[ChromaBits]);
			w_s25 <= clip(qd_w_s[ChromaBits]);
		end
	end

	assign out_valid = v_s25;
	assign lightness = l_s25;
	assign u_star    = signed'(u_s25);
	assign v_star    = signed'(w_s25);

endmodule

// ----- hdl/xyz_to_cie_luv.sv -----
// Top level of the CIE XYZ to L*u*v* converter: white registers, pipelines, output skid.
// Depends on xtl_pkg, xtl_lum and xtl_chroma.
//
// Channel  Direction  Handshake           Payload
// s_*      in         s_tvalid/s_tready   tdata: x_value, y_value, z_value
// m_*      out        m_tvalid/m_tready   tdata: lightness, u_star, v_star
// cfg_*    in         cfg_valid/cfg_ready index 0..2 selects white_x, white_y, white_z
//
// One item is accepted per clock while the skid register is empty; the path to its result runs through the
// 54-stage quotient and 18-stage cube root of the lightness path and then the chroma divider.
// Reset clears the pipeline valid bits and loads the D65 white.
// A stall on m_* fills the skid register, then holds the whole pipeline; nothing is lost.
module xyz_to_cie_luv (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // x_value, y_value, z_value
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata,   // lightness, u_star, v_star, zero fill
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	logic [15:0] white_x_q, white_y_q, white_z_q;
	xtl_pkg::white_t wnz;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			white_x_q <= xtl_pkg::WhiteXReset;
			white_y_q <= xtl_pkg::WhiteYReset;
			white_z_q <= xtl_pkg::WhiteZReset;
		end else if (cfg_valid) begin
			case (cfg_index)
				xtl_pkg::RegWhiteX: begin
					white_x_q <= cfg_data;
				end
				xtl_pkg::RegWhiteY: begin
					white_y_q <= cfg_data;
				end
				xtl_pkg::RegWhiteZ: begin
					white_z_q <= cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

	assign wnz.wx = (white_x_q == 16'd0) ? 16'd1 : white_x_q;
	assign wnz.wy = (white_y_q == 16'd0) ? 16'd1 : white_y_q;
	assign wnz.wz = (white_z_q == 16'd0) ? 16'd1 : white_z_q;

	logic            en;
	xtl_pkg::xyz_t   in_pix;
	logic            lum_v;
	xtl_pkg::xyz_t   lum_pix;
	logic [15:0]     lum_l;
	logic            res_v;
	logic [15:0]     res_l;
	logic signed [17:0] res_u, res_w;
	logic [51:0]     res_d;
	logic [51:0]     out_data_q, skid_data_q;
	logic            out_v_q, skid_v_q;

	assign en       = ~skid_v_q;
	assign s_tready = en;

	assign in_pix.x = s_tdata[15:0];
	assign in_pix.y = s_tdata[31:16];
	assign in_pix.z = s_tdata[47:32];

	xtl_lum u_lum (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (s_tvalid),
		.in_pix    (in_pix),
		.white_y   (wnz.wy),
		.out_valid (lum_v),
		.out_pix   (lum_pix),
		.lightness (lum_l)
	);

	xtl_chroma u_chroma (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (lum_v),
		.in_pix    (lum_pix),
		.in_light  (lum_l),
		.white     (wnz),
		.out_valid (res_v),
		.lightness (res_l),
		.u_star    (res_u),
		.v_star    (res_w)
	);

	assign res_d = {res_w, res_u, res_l};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (en) begin
			if (res_v) begin
				if (!out_v_q || m_tready) begin
					out_v_q <= 1'b1;
				end else begin
					skid_v_q <= 1'b1;
				end
			end else if (m_tready) begin
				out_v_q <= 1'b0;
			end
		end else if (!out_v_q || m_tready) begin
			out_v_q  <= 1'b1;
			skid_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (res_v) begin
				if (!out_v_q || m_tready) begin
					out_data_q <= res_d;
				end else begin
					skid_data_q <= res_d;
				end
			end
		end else if (!out_v_q || m_tready) begin
			out_data_q <= skid_data_q;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = {4'd0, out_data_q};

endmodule
